>>> rtl/core/clpg_pkg.sv
// ----------------------------------------------------------------------------
// clpg_pkg: shared types and constants of the clipped line pixel generator
// Register indexes, item kinds and the configuration register bundle.
// ----------------------------------------------------------------------------
package clpg_pkg;

	localparam int CLPG_COORD_BITS = 12;
	localparam int CLPG_IDX_BITS   = 3;
	localparam int CLPG_CFG_BITS   = 32;

	typedef enum logic [CLPG_IDX_BITS-1:0] {
		REG_CLIP_LEFT   = 3'd0,
		REG_CLIP_TOP    = 3'd1,
		REG_CLIP_WIDTH  = 3'd2,
		REG_CLIP_HEIGHT = 3'd3,
		REG_BPP         = 3'd4,
		REG_ROW_PITCH   = 3'd5,
		REG_FRAME_BASE  = 3'd6
	} reg_idx_t;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_t;

	typedef struct packed {
		logic [10:0] clip_left;
		logic [10:0] clip_top;
		logic [11:0] clip_width;
		logic [11:0] clip_height;
		logic [2:0]  bytes_per_pixel;
		logic [13:0] row_pitch;
		logic [31:0] frame_base;
	} cfg_t;

	localparam logic [2:0]  BPP_RESET   = 3'd4;
	localparam logic [13:0] PITCH_RESET = 14'd4096;

endpackage

>>> rtl/core/clpg_regs.sv
// ----------------------------------------------------------------------------
// clpg_regs: configuration registers
// Write-only register file for the clip rectangle and frame buffer layout.
// ----------------------------------------------------------------------------
module clpg_regs
	import clpg_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CLPG_IDX_BITS-1:0] cfg_index,
	input  logic [CLPG_CFG_BITS-1:0] cfg_data,
	output cfg_t                     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_left       <= '0;
			cfg_q.clip_top        <= '0;
			cfg_q.clip_width      <= '0;
			cfg_q.clip_height     <= '0;
			cfg_q.bytes_per_pixel <= BPP_RESET;
			cfg_q.row_pitch       <= PITCH_RESET;
			cfg_q.frame_base      <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CLIP_LEFT:   cfg_q.clip_left       <= cfg_data[10:0];
				REG_CLIP_TOP:    cfg_q.clip_top        <= cfg_data[10:0];
				REG_CLIP_WIDTH:  cfg_q.clip_width      <= cfg_data[11:0];
				REG_CLIP_HEIGHT: cfg_q.clip_height     <= cfg_data[11:0];
				REG_BPP:         cfg_q.bytes_per_pixel <= cfg_data[2:0];
				REG_ROW_PITCH:   cfg_q.row_pitch       <= cfg_data[13:0];
				REG_FRAME_BASE:  cfg_q.frame_base      <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/clpg_walker.sv
// ----------------------------------------------------------------------------
// clpg_walker: line walk state
// Sets up the walk on a start item and advances one pixel per step item.
// ----------------------------------------------------------------------------
module clpg_walker
	import clpg_pkg::*;
#(
	parameter int COORD_BITS = CLPG_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  action_t               action,
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [31:0]           line_color,
	output logic                  pix_valid,
	output logic [COORD_BITS-1:0] pix_x,
	output logic [COORD_BITS-1:0] pix_y,
	output logic [31:0]           pix_color,
	output logic                  pix_last
);

	localparam int C = COORD_BITS;

	logic [C-1:0] cur_x_q, cur_y_q, major_q, minor_q, steps_q;
	logic [C:0]   err_q;
	logic         x_neg_q, y_neg_q, x_major_q, busy_q;
	logic [31:0]  color_q;

	logic [C:0]   dx_d, dy_d, dx_n, dy_n;
	logic [C-1:0] dx_abs, dy_abs, major_d, minor_d;
	logic         x_neg_d, y_neg_d, x_major_d;
	logic [C:0]   err_sum, err_nxt;
	logic         minor_move;
	logic [C-1:0] x_adv, y_adv;

	assign dx_d    = {end_x[C-1], end_x} - {start_x[C-1], start_x};
	assign dy_d    = {end_y[C-1], end_y} - {start_y[C-1], start_y};
	assign dx_n    = -dx_d;
	assign dy_n    = -dy_d;
	assign x_neg_d = dx_d[C];
	assign y_neg_d = dy_d[C];
	assign dx_abs  = x_neg_d ? dx_n[C-1:0] : dx_d[C-1:0];
	assign dy_abs  = y_neg_d ? dy_n[C-1:0] : dy_d[C-1:0];
	assign x_major_d = dx_abs >= dy_abs;
	assign major_d   = x_major_d ? dx_abs : dy_abs;
	assign minor_d   = x_major_d ? dy_abs : dx_abs;

	assign err_sum    = err_q + {1'b0, minor_q};
	assign minor_move = err_sum >= {1'b0, major_q};
	assign err_nxt    = minor_move ? err_sum - {1'b0, major_q} : err_sum;

	always_comb begin
		x_adv = cur_x_q;
		y_adv = cur_y_q;
		if (x_major_q || minor_move) begin
			x_adv = x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (!x_major_q || minor_move) begin
			y_adv = y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			err_q     <= '0;
			major_q   <= '0;
			minor_q   <= '0;
			steps_q   <= '0;
			x_neg_q   <= 1'b0;
			y_neg_q   <= 1'b0;
			x_major_q <= 1'b0;
			busy_q    <= 1'b0;
			color_q   <= '0;
		end else if (accept && action == ACT_START) begin
			cur_x_q   <= start_x;
			cur_y_q   <= start_y;
			err_q     <= {2'b00, major_d[C-1:1]};
			major_q   <= major_d;
			minor_q   <= minor_d;
			steps_q   <= major_d;
			x_neg_q   <= x_neg_d;
			y_neg_q   <= y_neg_d;
			x_major_q <= x_major_d;
			busy_q    <= 1'b1;
			color_q   <= line_color;
		end else if (accept && busy_q) begin
			if (steps_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				err_q   <= err_nxt;
				cur_x_q <= x_adv;
				cur_y_q <= y_adv;
				steps_q <= steps_q - 1'b1;
			end
		end
	end

	assign pix_valid = accept && action == ACT_STEP && busy_q;
	assign pix_x     = cur_x_q;
	assign pix_y     = cur_y_q;
	assign pix_color = color_q;
	assign pix_last  = steps_q == '0;

endmodule

>>> rtl/core/clpg_addr.sv
// ----------------------------------------------------------------------------
// clpg_addr: address and clip pipeline
// Scales the pixel coordinates, tests the clip rectangle and forms the
// frame buffer address, then holds the result for the receiver.
// ----------------------------------------------------------------------------
module clpg_addr
	import clpg_pkg::*;
#(
	parameter int COORD_BITS = CLPG_COORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  pix_valid,
	input  logic [COORD_BITS-1:0] pix_x,
	input  logic [COORD_BITS-1:0] pix_y,
	input  logic [31:0]           pix_color,
	input  logic                  pix_last,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COORD_BITS-1:0] out_x,
	output logic [COORD_BITS-1:0] out_y,
	output logic [31:0]           out_addr,
	output logic [31:0]           out_color,
	output logic                  out_visible,
	output logic                  out_last
);

	localparam int C  = COORD_BITS;
	localparam int VW = ((C > 12) ? C : 12) + 2;

	logic         v_s1, v_s2, v_q;
	logic [C-1:0] x_s1, y_s1, x_s2, y_s2, x_q, y_q;
	logic [31:0]  color_s1, color_s2, color_q;
	logic         last_s1, last_s2, last_q;
	logic [31:0]  xoff_s2, yoff_s2, addr_q;
	logic         vis_s2, vis_q;

	logic         en_s1, en_s2, en_q;
	logic [31:0]  x_ext, y_ext, xoff, yoff;
	logic [VW-1:0] xv, yv, left_v, top_v, right_v, bottom_v;
	logic         vis;

	assign en_q  = !v_q || out_ready;
	assign en_s2 = !v_s2 || en_q;
	assign en_s1 = !v_s1 || en_s2;
	assign in_ready = en_s1;

	assign x_ext = {{(32-C){x_s1[C-1]}}, x_s1};
	assign y_ext = {{(32-C){y_s1[C-1]}}, y_s1};
	assign xoff  = x_ext * {29'd0, cfg.bytes_per_pixel};
	assign yoff  = y_ext * {18'd0, cfg.row_pitch};

	assign xv       = {{(VW-C){x_s1[C-1]}}, x_s1};
	assign yv       = {{(VW-C){y_s1[C-1]}}, y_s1};
	assign left_v   = {{(VW-11){1'b0}}, cfg.clip_left};
	assign top_v    = {{(VW-11){1'b0}}, cfg.clip_top};
	assign right_v  = left_v + {{(VW-12){1'b0}}, cfg.clip_width};
	assign bottom_v = top_v + {{(VW-12){1'b0}}, cfg.clip_height};
	assign vis = $signed(xv) >= $signed(left_v) && $signed(xv) < $signed(right_v)
		&& $signed(yv) >= $signed(top_v) && $signed(yv) < $signed(bottom_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_q)  v_q  <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			x_s1     <= pix_x;
			y_s1     <= pix_y;
			color_s1 <= pix_color;
			last_s1  <= pix_last;
		end
		if (en_s2) begin
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			color_s2 <= color_s1;
			last_s2  <= last_s1;
			xoff_s2  <= xoff;
			yoff_s2  <= yoff;
			vis_s2   <= vis;
		end
		if (en_q) begin
			x_q     <= x_s2;
			y_q     <= y_s2;
			color_q <= color_s2;
			last_q  <= last_s2;
			vis_q   <= vis_s2;
			addr_q  <= cfg.frame_base + xoff_s2 + yoff_s2;
		end
	end

	assign out_valid   = v_q;
	assign out_x       = x_q;
	assign out_y       = y_q;
	assign out_addr    = addr_q;
	assign out_color   = color_q;
	assign out_visible = vis_q;
	assign out_last    = last_q;

endmodule

>>> rtl/core/clipped_line_pixel_generator.sv
// ----------------------------------------------------------------------------
// clipped_line_pixel_generator: line pixel generator with rectangle clip
// Walks a line between two endpoints and emits one frame buffer write per
// step item while a line is active.
//
// Input stream: tuser carries the item kind (start or step). A start item
// loads both endpoints and the color and gives no result; each step item
// while a line is active gives one pixel, the first endpoint first. A step
// while idle is dropped; a start while active restarts the walk.
// Output stream: one item per pixel with coordinates, byte address and
// color in tdata, the clip flag in tuser and the final pixel on tlast.
// Pipeline: a pixel passes the input register, the scale and clip
// register, then the address register. Throughput: one item per cycle
// while the receiver does not stall.
// Receiver stall: the output register holds; the two inner stages keep
// filling, and the input stalls only once all three are full.
// Reset: registers return to their defaults, the walker goes idle. The user
// must do configuration writes only while no item is in flight (not enforced).
// ----------------------------------------------------------------------------
module clipped_line_pixel_generator
	import clpg_pkg::*;
#(
	parameter int COORD_BITS = CLPG_COORD_BITS,
	localparam int IN_W  = ((4 * COORD_BITS + 32 + 7) / 8) * 8,
	localparam int OUT_W = ((2 * COORD_BITS + 64 + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CLPG_IDX_BITS-1:0] cfg_index,
	input  logic [CLPG_CFG_BITS-1:0] cfg_data,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// start_x, start_y, end_x, end_y, line_color
	input  logic [IN_W-1:0]          s_tdata,
	// action
	input  logic [0:0]               s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// pixel_x, pixel_y, byte_address, pixel_color
	output logic [OUT_W-1:0]         m_tdata,
	// visible
	output logic [0:0]               m_tuser,
	output logic                     m_tlast
);

	localparam int C = COORD_BITS;

	cfg_t         cfg;
	logic         accept;
	logic         pix_valid, pix_last;
	logic [C-1:0] pix_x, pix_y, out_x, out_y;
	logic [31:0]  pix_color, out_addr, out_color;
	logic         out_visible;

	assign accept = s_tvalid && s_tready;

	clpg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	clpg_walker #(.COORD_BITS(C)) u_walker (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.action     (action_t'(s_tuser[0])),
		.start_x    (s_tdata[C-1:0]),
		.start_y    (s_tdata[2*C-1:C]),
		.end_x      (s_tdata[3*C-1:2*C]),
		.end_y      (s_tdata[4*C-1:3*C]),
		.line_color (s_tdata[4*C+31:4*C]),
		.pix_valid  (pix_valid),
		.pix_x      (pix_x),
		.pix_y      (pix_y),
		.pix_color  (pix_color),
		.pix_last   (pix_last)
	);

	clpg_addr #(.COORD_BITS(C)) u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.pix_valid   (pix_valid),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.pix_color   (pix_color),
		.pix_last    (pix_last),
		.in_ready    (s_tready),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_addr    (out_addr),
		.out_color   (out_color),
		.out_visible (out_visible),
		.out_last    (m_tlast)
	);

	assign m_tdata = OUT_W'({out_color, out_addr, out_y, out_x});
	assign m_tuser = out_visible;

endmodule

>>> rtl/core/clpg_checker.sv
// ----------------------------------------------------------------------------
// clpg_checker: port checks for the line pixel generator
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module clpg_checker
	import clpg_pkg::*;
#(
	parameter int COORD_BITS = CLPG_COORD_BITS,
	localparam int OUT_W = ((2 * COORD_BITS + 64 + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic [0:0]       m_tuser,
	input logic             m_tlast
);

	localparam int C = COORD_BITS;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
			&& $stable(m_tuser) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with free output");

	a_vis_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[C-1] && !m_tdata[2*C-1])
		else $error("negative pixel marked visible");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tvalid && !m_tvalid ##1 !s_tvalid && !m_tvalid ##1 !s_tvalid
			&& !m_tvalid |=> !m_tvalid)
		else $error("output item without input");

endmodule

bind clipped_line_pixel_generator clpg_checker #(.COORD_BITS(COORD_BITS)) u_clpg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
